### src/ppft_pkg.sv
// Package for the PID position force terms core: payload types, register
// indexes, reset values and the microcode program of the sequencer.
// No dependencies.
package ppft_pkg;

	localparam int CFG_W   = 47;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W    = 3;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int INT_W   = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_PROP_LIMIT     = 3'd1,
		REG_DEADBAND_WIDTH = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_INTEG_GAIN     = 3'd4,
		REG_DAMP_GAIN      = 3'd5,
		REG_DAMP_LIMIT     = 3'd6
	} cfg_idx_t;

	localparam logic signed [15:0] PROP_GAIN_RST      = 16'sd256;
	localparam logic [14:0]        PROP_LIMIT_RST     = 15'h7fff;
	localparam logic [14:0]        DEADBAND_WIDTH_RST = 15'h0000;
	localparam logic [46:0]        INTEGRAL_LIMIT_RST = 47'h7fff_ffff_ffff;
	localparam logic signed [31:0] INTEG_GAIN_RST     = 32'sd0;
	localparam logic signed [15:0] DAMP_GAIN_RST      = 16'sd0;
	localparam logic [14:0]        DAMP_LIMIT_RST     = 15'h7fff;

	typedef struct packed {
		logic signed [15:0] target_pos;
		logic signed [15:0] measured_pos;
		logic signed [15:0] shaft_speed;
		logic [15:0]        elapsed_us;
	} item_t;

	typedef struct packed {
		logic signed [15:0] prop_force;
		logic signed [15:0] integ_force;
		logic signed [15:0] damp_force;
	} result_t;

	// multiplier operand A
	typedef enum logic [2:0] {
		A_ERR   = 3'd0,
		A_DIFF  = 3'd1,
		A_IHI   = 3'd2,
		A_ILO   = 3'd3,
		A_DGAIN = 3'd4
	} a_sel_t;

	// multiplier operand B
	typedef enum logic [1:0] {
		B_DT    = 2'd0,
		B_PGAIN = 2'd1,
		B_IGAIN = 2'd2,
		B_SPEED = 2'd3
	} b_sel_t;

	// what the datapath does with the previous product
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_ACC   = 3'd1,
		OP_PROP  = 3'd2,
		OP_HI    = 3'd3,
		OP_INTEG = 3'd4,
		OP_DAMP  = 3'd5
	} op_t;

	// step advance condition
	typedef enum logic [1:0] {
		COND_ALWAYS = 2'd0,
		COND_IN     = 2'd1,
		COND_OUT    = 2'd2
	} cond_t;

	typedef struct packed {
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		logic            mul_en;
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] nxt;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_WAIT = 3'd0;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			3'd0: w = '{A_ERR,   B_DT,    1'b0, OP_NONE,  COND_IN,     3'd1};
			3'd1: w = '{A_ERR,   B_DT,    1'b1, OP_NONE,  COND_ALWAYS, 3'd2};
			3'd2: w = '{A_DIFF,  B_PGAIN, 1'b1, OP_ACC,   COND_ALWAYS, 3'd3};
			3'd3: w = '{A_IHI,   B_IGAIN, 1'b1, OP_PROP,  COND_ALWAYS, 3'd4};
			3'd4: w = '{A_ILO,   B_IGAIN, 1'b1, OP_HI,    COND_ALWAYS, 3'd5};
			3'd5: w = '{A_DGAIN, B_SPEED, 1'b1, OP_INTEG, COND_ALWAYS, 3'd6};
			3'd6: w = '{A_ERR,   B_DT,    1'b0, OP_DAMP,  COND_OUT,    PC_WAIT};
			default: w = '{A_ERR, B_DT,   1'b0, OP_NONE,  COND_ALWAYS, PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

### src/ppft_item_if.sv
// Valid/ready channel carrying one control tick (ppft_pkg::item_t).
// Depends on ppft_pkg.
interface ppft_item_if;
	logic            valid;
	logic            ready;
	ppft_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### src/ppft_result_if.sv
// Valid/ready channel carrying the three force terms (ppft_pkg::result_t).
// Depends on ppft_pkg.
interface ppft_result_if;
	logic              valid;
	logic              ready;
	ppft_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### src/pid_position_force_terms_core.sv
// PID position force terms: microcoded sequencer around one shared 33x33
// signed multiplier. Depends on ppft_pkg, ppft_item_if, ppft_result_if.
//
//   channel   direction  contents
//   item      sink       target_pos, measured_pos, shaft_speed, elapsed_us
//   result    source     prop_force, integ_force, damp_force
//   cfg_*     write      cfg_we, cfg_index (0..6), cfg_data (47 bits)
//
// An item runs through seven steps: the wait step that takes its transfer,
// five multiplier steps (error*dt, gain*diff, two halves of the 48x32
// integral product, gain*speed) and the commit step, which loads its result
// into the output register. A new item is taken only at the wait step, after
// the last one has committed; a full output register holds the commit step
// until the result is taken. Reset clears the step counter, the integral, the
// output valid and loads the register reset values.
module pid_position_force_terms_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ppft_item_if.sink                            item,
	ppft_result_if.source                        result,
	input  logic                                 cfg_we,
	input  logic [ppft_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppft_pkg::CFG_W-1:0]           cfg_data
);

	// configuration
	logic signed [15:0] prop_gain_q;
	logic [14:0]        prop_limit_q;
	logic [14:0]        deadband_width_q;
	logic [46:0]        integral_limit_q;
	logic signed [31:0] integ_gain_q;
	logic signed [15:0] damp_gain_q;
	logic [14:0]        damp_limit_q;

	// sequencer and datapath
	logic [ppft_pkg::PC_W-1:0]          pc_q;
	ppft_pkg::ucode_t                   uc;
	ppft_pkg::item_t                    in_q;
	logic signed [ppft_pkg::INT_W-1:0]  integ_q;
	logic signed [ppft_pkg::PROD_W-1:0] prod_q;
	logic signed [55:0]                 hi_q;
	logic signed [15:0]                 p_q;
	logic signed [15:0]                 f_q;
	ppft_pkg::result_t                  out_q;
	logic                               out_valid_q;

	logic signed [16:0]                 err_raw;
	logic signed [16:0]                 err_db;
	logic signed [16:0]                 db_s;
	logic signed [16:0]                 diff;
	logic signed [ppft_pkg::MUL_W-1:0]  mul_a;
	logic signed [ppft_pkg::MUL_W-1:0]  mul_b;
	logic signed [ppft_pkg::PROD_W-1:0] mul_p;
	logic signed [48:0]                 acc_sum;
	logic signed [48:0]                 ilim_s;
	logic signed [ppft_pkg::INT_W-1:0]  acc_clamped;
	logic signed [79:0]                 ig_sum;
	logic signed [47:0]                 ig_shr;
	logic signed [15:0]                 ig_sat;
	logic signed [15:0]                 d_clamped;
	logic                               in_xfer;
	logic                               out_free;
	logic                               commit;
	logic                               advance;

	function automatic logic signed [15:0] clamp_lim(
		input logic signed [24:0] x,
		input logic [14:0]        lim
	);
		logic signed [24:0] pos_l;
		logic signed [24:0] neg_l;
		logic signed [15:0] r;
		pos_l = $signed({10'd0, lim});
		neg_l = -pos_l;
		if (x > pos_l) begin
			r = pos_l[15:0];
		end else if (x < neg_l) begin
			r = neg_l[15:0];
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= ppft_pkg::PROP_GAIN_RST;
			prop_limit_q     <= ppft_pkg::PROP_LIMIT_RST;
			deadband_width_q <= ppft_pkg::DEADBAND_WIDTH_RST;
			integral_limit_q <= ppft_pkg::INTEGRAL_LIMIT_RST;
			integ_gain_q     <= ppft_pkg::INTEG_GAIN_RST;
			damp_gain_q      <= ppft_pkg::DAMP_GAIN_RST;
			damp_limit_q     <= ppft_pkg::DAMP_LIMIT_RST;
		end else if (cfg_we) begin
			case (ppft_pkg::cfg_idx_t'(cfg_index))
				ppft_pkg::REG_PROP_GAIN:      prop_gain_q      <= $signed(cfg_data[15:0]);
				ppft_pkg::REG_PROP_LIMIT:     prop_limit_q     <= cfg_data[14:0];
				ppft_pkg::REG_DEADBAND_WIDTH: deadband_width_q <= cfg_data[14:0];
				ppft_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[46:0];
				ppft_pkg::REG_INTEG_GAIN:     integ_gain_q     <= $signed(cfg_data[31:0]);
				ppft_pkg::REG_DAMP_GAIN:      damp_gain_q      <= $signed(cfg_data[15:0]);
				ppft_pkg::REG_DAMP_LIMIT:     damp_limit_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign uc = ppft_pkg::ucode_rom(pc_q);

	assign item.ready = (uc.cond == ppft_pkg::COND_IN);
	assign in_xfer    = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign commit     = (uc.op == ppft_pkg::OP_DAMP) && out_free;

	always_comb begin
		case (uc.cond)
			ppft_pkg::COND_IN:  advance = in_xfer;
			ppft_pkg::COND_OUT: advance = out_free;
			default:            advance = 1'b1;
		endcase
	end

	// deadband: shrink the error toward zero
	assign err_raw = 17'(in_q.target_pos) - 17'(in_q.measured_pos);
	assign diff    = 17'(in_q.measured_pos) - 17'(in_q.target_pos);
	assign db_s    = $signed({2'b00, deadband_width_q});

	always_comb begin
		if (err_raw > 17'sd0) begin
			err_db = (err_raw < db_s) ? 17'sd0 : err_raw - db_s;
		end else begin
			err_db = (err_raw > -db_s) ? 17'sd0 : err_raw + db_s;
		end
	end

	// shared multiplier operand selection
	always_comb begin
		case (uc.a_sel)
			ppft_pkg::A_ERR:   mul_a = 33'(err_db);
			ppft_pkg::A_DIFF:  mul_a = 33'(diff);
			ppft_pkg::A_IHI:   mul_a = 33'($signed(integ_q[47:24]));
			ppft_pkg::A_ILO:   mul_a = $signed({9'd0, integ_q[23:0]});
			ppft_pkg::A_DGAIN: mul_a = 33'(damp_gain_q);
			default:           mul_a = '0;
		endcase
		case (uc.b_sel)
			ppft_pkg::B_DT:    mul_b = $signed({17'd0, in_q.elapsed_us});
			ppft_pkg::B_PGAIN: mul_b = 33'(prop_gain_q);
			ppft_pkg::B_IGAIN: mul_b = 33'(integ_gain_q);
			ppft_pkg::B_SPEED: mul_b = 33'(in_q.shaft_speed);
			default:           mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// integral update with anti-windup clamp
	assign acc_sum = 49'(integ_q) + 49'($signed(prod_q[33:0]));
	assign ilim_s  = $signed({2'b00, integral_limit_q});

	always_comb begin
		if (acc_sum > ilim_s) begin
			acc_clamped = ilim_s[47:0];
		end else if (acc_sum < -ilim_s) begin
			acc_clamped = 48'(-ilim_s);
		end else begin
			acc_clamped = acc_sum[47:0];
		end
	end

	// integral force: (hi << 24) + lo, floor shift by 32, saturate
	assign ig_sum = (80'(hi_q) <<< 24) + 80'($signed(prod_q[56:0]));
	assign ig_shr = ig_sum[79:32];

	always_comb begin
		if (ig_shr > 48'sd32767) begin
			ig_sat = 16'sh7fff;
		end else if (ig_shr < -48'sd32768) begin
			ig_sat = 16'sh8000;
		end else begin
			ig_sat = ig_shr[15:0];
		end
	end

	assign d_clamped = clamp_lim(prod_q[32:8], damp_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ppft_pkg::PC_WAIT;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pc_q <= uc.nxt;
			end
			if (uc.op == ppft_pkg::OP_ACC) begin
				integ_q <= acc_clamped;
			end
			out_valid_q <= commit || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_q <= item.data;
		end
		if (uc.mul_en) begin
			prod_q <= mul_p;
		end
		case (uc.op)
			ppft_pkg::OP_PROP:  p_q  <= clamp_lim(prod_q[32:8], prop_limit_q);
			ppft_pkg::OP_HI:    hi_q <= prod_q[55:0];
			ppft_pkg::OP_INTEG: f_q  <= ig_sat;
			default: ;
		endcase
		if (commit) begin
			out_q.prop_force  <= p_q;
			out_q.integ_force <= f_q;
			out_q.damp_force  <= d_clamped;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

### dv/force_scoreboard_pkg.sv
// Scoreboard for the PID position force terms core: mirrors the register file
// and the error integral, predicts the three force terms of every tick.
// Depends on ppft_pkg.
package force_scoreboard_pkg;
	import ppft_pkg::*;

	class force_scoreboard;
		logic signed [15:0] prop_gain;
		logic [14:0]        prop_limit;
		logic [14:0]        deadband;
		logic [46:0]        integ_limit;
		logic signed [31:0] integ_gain;
		logic signed [15:0] damp_gain;
		logic [14:0]        damp_limit;
		longint             error_integral;
		result_t            expected_forces[$];
		int                 errors;
		int                 checked;

		function new();
			prop_gain      = PROP_GAIN_RST;
			prop_limit     = PROP_LIMIT_RST;
			deadband       = DEADBAND_WIDTH_RST;
			integ_limit    = INTEGRAL_LIMIT_RST;
			integ_gain     = INTEG_GAIN_RST;
			damp_gain      = DAMP_GAIN_RST;
			damp_limit     = DAMP_LIMIT_RST;
			error_integral = 0;
			errors         = 0;
			checked        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PROP_GAIN:      prop_gain   = val[15:0];
				REG_PROP_LIMIT:     prop_limit  = val[14:0];
				REG_DEADBAND_WIDTH: deadband    = val[14:0];
				REG_INTEGRAL_LIMIT: integ_limit = val[46:0];
				REG_INTEG_GAIN:     integ_gain  = val[31:0];
				REG_DAMP_GAIN:      damp_gain   = val[15:0];
				REG_DAMP_LIMIT:     damp_limit  = val[14:0];
				default: ;
			endcase
		endfunction

		static function longint clamp_mag(longint x, longint lim);
			if (x > lim)
				return lim;
			if (x < -lim)
				return -lim;
			return x;
		endfunction

		function result_t force_terms(item_t it);
			longint             tgt, pos, spd, dt, err, db, p, d;
			logic signed [95:0] prod, gain;
			result_t            r;
			tgt = $signed(it.target_pos);
			pos = $signed(it.measured_pos);
			spd = $signed(it.shaft_speed);
			dt  = it.elapsed_us;
			db  = deadband;

			p = clamp_mag((pos - tgt) * longint'(prop_gain) >>> 8, prop_limit);

			// shrink the error toward zero by the deadband
			err = tgt - pos;
			if (err > 0)
				err = (err < db) ? 0 : err - db;
			else
				err = (err > -db) ? 0 : err + db;
			error_integral = clamp_mag(error_integral + err * dt, longint'(integ_limit));

			// full-width product, floor shift, then saturate
			prod = error_integral;
			gain = integ_gain;
			prod = (prod * gain) >>> 32;
			if (prod > 32767)
				r.integ_force = 16'h7fff;
			else if (prod < -32768)
				r.integ_force = 16'h8000;
			else
				r.integ_force = prod[15:0];

			d = clamp_mag(longint'(damp_gain) * spd >>> 8, damp_limit);

			r.prop_force = p[15:0];
			r.damp_force = d[15:0];
			return r;
		endfunction

		function void note_tick(item_t it);
			expected_forces.push_back(force_terms(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_forces.size() == 0) begin
				$error("force result %h with no tick outstanding", got);
				errors++;
				return;
			end
			want = expected_forces.pop_front();
			checked++;
			if (got.prop_force !== want.prop_force) begin
				$error("prop_force: expected %0d, got %0d",
					$signed(want.prop_force), $signed(got.prop_force));
				errors++;
			end
			if (got.integ_force !== want.integ_force) begin
				$error("integ_force: expected %0d, got %0d",
					$signed(want.integ_force), $signed(got.integ_force));
				errors++;
			end
			if (got.damp_force !== want.damp_force) begin
				$error("damp_force: expected %0d, got %0d",
					$signed(want.damp_force), $signed(got.damp_force));
				errors++;
			end
		endfunction
	endclass

endpackage

### dv/tb.sv
// Top-level testbench for pid_position_force_terms_core: directed ticks, then
// random phases under varying idling, checked by force_scoreboard_pkg.
// Depends on ppft_pkg, the channel interfaces and force_scoreboard_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppft_pkg::*;
	import force_scoreboard_pkg::*;

	// no register at this index; the core must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int TICKS_PER_PHASE = 90;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ppft_item_if   item();
	ppft_result_if result();

	pid_position_force_terms_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	force_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_off       = 0;
	int n_sent         = 0;
	int n_settings     = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: errors");
		$finish;
	end

	// result side: long hold-off first, otherwise random stalls
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result.ready = 1'b0;
				hold_off--;
			end else
				result.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item.valid && item.ready)
				sb.note_tick(item.data);
			if (result.valid && result.ready)
				sb.check_result(result.data);
		end
	end

	task automatic send_tick(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item.valid = 1'b0;
			item.data  = {$urandom, $urandom};
			@(negedge clk);
		end
		item.valid = 1'b1;
		item.data  = it;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic drain();
		item.valid = 1'b0;
		while (sb.expected_forces.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	function automatic item_t tick(int tgt, int pos, int spd, int dt);
		item_t it;
		it.target_pos   = 16'(tgt);
		it.measured_pos = 16'(pos);
		it.shaft_speed  = 16'(spd);
		it.elapsed_us   = 16'(dt);
		return it;
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic item_t rand_tick();
		item_t it;
		it.target_pos = pick16();
		// mostly near the target, where the deadband matters
		if ($urandom_range(2) != 0)
			it.measured_pos = it.target_pos + 16'($urandom_range(600)) - 16'd300;
		else
			it.measured_pos = pick16();
		it.shaft_speed = pick16();
		it.elapsed_us  = ($urandom_range(3) == 0) ? pick16() : 16'($urandom_range(2000));
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg(int w, bit sgn);
		logic [63:0] mask, r;
		mask = (64'd1 << w) - 64'd1;
		r    = {$urandom, $urandom};
		case ($urandom_range(5))
			0: r = sgn ? 64'd1 << (w - 1) : 64'd0;
			1: r = sgn ? (64'd1 << (w - 1)) - 64'd1 : mask;
			2: r = (sgn && r[63]) ? -(r & 64'h3ff) : (r & 64'h3ff);
			3: r = r >> $urandom_range(60, 8);
			default: ;
		endcase
		return CFG_W'(r & mask);
	endfunction

	task automatic random_settings();
		write_reg(REG_PROP_GAIN,      pick_reg(16, 1'b1));
		write_reg(REG_PROP_LIMIT,     pick_reg(15, 1'b0));
		write_reg(REG_DEADBAND_WIDTH, pick_reg(15, 1'b0));
		write_reg(REG_INTEGRAL_LIMIT, pick_reg(47, 1'b0));
		write_reg(REG_INTEG_GAIN,     pick_reg(32, 1'b1));
		write_reg(REG_DAMP_GAIN,      pick_reg(16, 1'b1));
		write_reg(REG_DAMP_LIMIT,     pick_reg(15, 1'b0));
		n_settings++;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int hold);
		random_settings();
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		hold_off       = hold;
		repeat (TICKS_PER_PHASE) send_tick(rand_tick());
		drain();
	endtask

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		item.valid = 1'b0;
		item.data  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: unity proportional gain, integral and damping off
		send_tick(tick(0, 0, 0, 0));
		send_tick(tick(32767, -32768, 32767, 65535));
		send_tick(tick(-32768, 32767, -32768, 65535));
		send_tick(tick(100, 90, -1, 1));
		drain();

		write_reg(REG_PROP_GAIN,      'h8000);
		write_reg(REG_PROP_LIMIT,     'h7fff);
		write_reg(REG_DEADBAND_WIDTH, 100);
		write_reg(REG_INTEGRAL_LIMIT, INTEGRAL_LIMIT_RST);
		write_reg(REG_INTEG_GAIN,     'h7fff_ffff);
		write_reg(REG_DAMP_GAIN,      'h7fff);
		write_reg(REG_DAMP_LIMIT,     1000);
		write_reg(REG_NONE,           '1);
		// errors inside, on and just past both edges of the deadband
		send_tick(tick(150, 100, 32767, 1000));
		send_tick(tick(200, 100, -32768, 1000));
		send_tick(tick(201, 100, 1, 1000));
		send_tick(tick(100, 150, -1, 1000));
		send_tick(tick(100, 200, 0, 1000));
		send_tick(tick(100, 201, 3, 1000));
		send_tick(tick(5, 5, -3, 1000));
		// wind the integral up until its force saturates, then back off
		repeat (3) send_tick(tick(32767, -32768, -32768, 65535));
		send_tick(tick(-32768, 32767, 0, 65535));
		drain();

		// zero limits, widest deadband
		write_reg(REG_PROP_GAIN,      'h7fff);
		write_reg(REG_PROP_LIMIT,     0);
		write_reg(REG_DEADBAND_WIDTH, 'h7fff);
		write_reg(REG_INTEGRAL_LIMIT, 0);
		write_reg(REG_INTEG_GAIN,     'h8000_0000);
		write_reg(REG_DAMP_GAIN,      'h8000);
		write_reg(REG_DAMP_LIMIT,     0);
		send_tick(tick(-32768, 32767, 32767, 65535));
		send_tick(tick(32767, -32768, -32768, 65535));
		drain();

		// anti-windup clamp in both directions, then a floor-rounded force
		write_reg(REG_PROP_LIMIT,     'h7fff);
		write_reg(REG_DEADBAND_WIDTH, 0);
		write_reg(REG_INTEGRAL_LIMIT, 1000000);
		write_reg(REG_DAMP_LIMIT,     'h7fff);
		send_tick(tick(1000, 0, 123, 2000));
		send_tick(tick(-1000, 0, -123, 3000));
		send_tick(tick(1, 0, 0, 0));
		drain();
		write_reg(REG_INTEG_GAIN, 'h1_0000);
		send_tick(tick(-1, 0, 0, 7));
		drain();

		run_phase(0, 0, 0);
		run_phase(88, 0, 0);
		run_phase(0, 88, 0);
		run_phase(14, 14, 0);
		// receiver holds off while ticks keep coming: fill up and stall input
		run_phase(0, 0, 80);

		$display("tb: %0d ticks sent, %0d force triples checked", n_sent, sb.checked);
		$display("tb: directed edge cases plus %0d random register settings", n_settings);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
